// File: rtl/assert_macros.svh
// assert_macros.svh: assertion macros for the drive command parser checkers.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, off while reset is applied.
`define SDCP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("sdcp assertion failed");

// Same, for an implication that fires only when a result beat is offered.
`define SDCP_ASSERT_OUT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) m_tvalid |-> (prop)) \
	else $error("sdcp output check failed");

`endif

// File: rtl/sdcp_pkg.sv
// sdcp_pkg: shared types, character codes, keyword tables and helpers for
// the serial drive command parser. No dependencies.
`timescale 1ns / 1ps

package sdcp_pkg;

	localparam int LINE_CAPACITY_DEF = 64;
	localparam int QUEUE_DEPTH       = 4;
	localparam int KW_COUNT          = 6;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_R     = 8'h52;

	// Command codes
	localparam logic [3:0] OPC_IDLE      = 4'd0;
	localparam logic [3:0] OPC_MOVE      = 4'd1;
	localparam logic [3:0] OPC_HALT      = 4'd2;
	localparam logic [3:0] OPC_ECHO      = 4'd3;
	localparam logic [3:0] OPC_DBG_SET   = 4'd4;
	localparam logic [3:0] OPC_DBG_CLR   = 4'd5;
	localparam logic [3:0] OPC_ENC_CLEAR = 4'd6;
	localparam logic [3:0] OPC_REPORT    = 4'd7;
	localparam logic [3:0] OPC_OTHER     = 4'd8;

	// Keyword text, first character in the highest used byte
	localparam logic [71:0] KW_STR [KW_COUNT] = '{
		72'("ESTOP"), 72'("PING"), 72'("DEBUG:ON"),
		72'("DEBUG:OFF"), 72'("RESET_ENC"), 72'("STATUS")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd5, 4'd4, 4'd8, 4'd9, 4'd9, 4'd6
	};
	localparam logic [3:0] KW_CODE [KW_COUNT] = '{
		OPC_HALT, OPC_ECHO, OPC_DBG_SET, OPC_DBG_CLR, OPC_ENC_CLEAR, OPC_REPORT
	};

	// Summary of one finished line, handed from front to back
	typedef struct packed {
		logic                empty;
		logic                is_drive;
		logic                drive_ok;
		logic [KW_COUNT-1:0] hits;
		logic [7:0]          lmag;
		logic                lneg;
		logic [7:0]          rmag;
		logic                rneg;
	} line_summary_t;

	// Character p of keyword k; p must be below the keyword length
	function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
		logic [71:0] s;
		logic [3:0]  idx;
		s   = KW_STR[k];
		idx = KW_LEN[k] - 4'd1 - p;
		return s[{idx, 3'b000} +: 8];
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// mag*10 + digit, saturating at 255
	function automatic logic [7:0] add_digit(input logic [7:0] mag, input logic [7:0] b);
		logic [11:0] v;
		v = {4'd0, mag} * 12'd10 + {8'd0, b[3:0]};
		return (v > 12'd255) ? 8'hFF : v[7:0];
	endfunction

endpackage

// File: rtl/sdcp_front.sv
// sdcp_front: byte classifier. Tracks line length, keyword matches and the
// drive form parse; emits a line summary on each newline. Uses sdcp_pkg.
`timescale 1ns / 1ps

module sdcp_front #(
	parameter int LINE_CAPACITY = sdcp_pkg::LINE_CAPACITY_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             in_byte,
	input  logic                   q_full,
	output logic                   push,
	output sdcp_pkg::line_summary_t push_data
);

	localparam int LW = $clog2(LINE_CAPACITY);

	// Drive parse phases
	localparam logic [3:0] PH_L      = 4'd0;
	localparam logic [3:0] PH_COLON  = 4'd1;
	localparam logic [3:0] PH_LSPACE = 4'd2;
	localparam logic [3:0] PH_LSIGN  = 4'd3;
	localparam logic [3:0] PH_LDIGIT = 4'd4;
	localparam logic [3:0] PH_LDONE  = 4'd5;
	localparam logic [3:0] PH_R      = 4'd6;
	localparam logic [3:0] PH_RCOLON = 4'd7;
	localparam logic [3:0] PH_RSPACE = 4'd8;
	localparam logic [3:0] PH_RSIGN  = 4'd9;
	localparam logic [3:0] PH_RDIGIT = 4'd10;
	localparam logic [3:0] PH_RDONE  = 4'd11;
	localparam logic [3:0] PH_WORD   = 4'd12;
	localparam logic [3:0] PH_BAD    = 4'd13;

	logic [LW-1:0]                 line_len_q, line_len_n;
	logic [LW-1:0]                 text_len_q, text_len_n;
	logic [sdcp_pkg::KW_COUNT-1:0] match_q, match_n;
	logic                          pend_q, pend_n;
	logic                          cut_q, cut_n;
	logic [3:0]                    phase_q, phase_n;
	logic [7:0]                    lmag_q, lmag_n, rmag_q, rmag_n;
	logic                          lneg_q, lneg_n, rneg_q, rneg_n;
	logic                          acc;
	logic [LW-1:0]                 text_n_chars;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	// Line summary from the current state, used when the newline arrives
	assign text_n_chars = text_len_q - LW'(pend_q);
	always_comb begin
		push_data.empty    = (text_n_chars == '0);
		push_data.is_drive = !(phase_q == PH_L || phase_q == PH_COLON || phase_q == PH_WORD);
		push_data.drive_ok = (phase_q >= PH_RSPACE) && (phase_q <= PH_RDONE);
		for (int i = 0; i < sdcp_pkg::KW_COUNT; i++) begin
			push_data.hits[i] = match_q[i] && (text_n_chars == LW'(sdcp_pkg::KW_LEN[i]));
		end
		push_data.lmag = lmag_q;
		push_data.lneg = lneg_q;
		push_data.rmag = rmag_q;
		push_data.rneg = rneg_q;
	end

	// Next state for one accepted beat
	always_comb begin
		line_len_n = line_len_q;
		text_len_n = text_len_q;
		match_n    = match_q;
		pend_n     = pend_q;
		cut_n      = cut_q;
		phase_n    = phase_q;
		lmag_n     = lmag_q;
		lneg_n     = lneg_q;
		rmag_n     = rmag_q;
		rneg_n     = rneg_q;
		push       = 1'b0;
		if (acc) begin
			if (in_byte == sdcp_pkg::CH_LF || line_len_q >= LW'(LINE_CAPACITY - 1)) begin
				// newline closes the line; a full buffer drops the byte and restarts
				push       = (in_byte == sdcp_pkg::CH_LF);
				line_len_n = '0;
				text_len_n = '0;
				match_n    = '1;
				pend_n     = 1'b0;
				cut_n      = 1'b0;
				phase_n    = PH_L;
				lmag_n     = '0;
				lneg_n     = 1'b0;
				rmag_n     = '0;
				rneg_n     = 1'b0;
			end else begin
				line_len_n = line_len_q + LW'(1);
				if (!cut_q) begin
					if (in_byte == sdcp_pkg::CH_NUL) begin
						cut_n = 1'b1;
					end else begin
						// a carriage return that was not last spoils every keyword
						if (pend_q) match_n = '0;
						pend_n = (in_byte == sdcp_pkg::CH_CR);
						if (in_byte != sdcp_pkg::CH_CR) begin
							for (int i = 0; i < sdcp_pkg::KW_COUNT; i++) begin
								if (text_len_q >= LW'(sdcp_pkg::KW_LEN[i]) ||
								    sdcp_pkg::kw_char(i, text_len_q[3:0]) != in_byte)
									match_n[i] = 1'b0;
							end
						end
						text_len_n = text_len_q + LW'(1);

						// drive form parse
						unique case (phase_q)
							PH_L: begin
								phase_n = (in_byte == sdcp_pkg::CH_L) ? PH_COLON : PH_WORD;
							end
							PH_COLON: begin
								phase_n = (in_byte == sdcp_pkg::CH_COLON) ? PH_LSPACE : PH_WORD;
							end
							PH_LSPACE: begin
								priority if (in_byte == sdcp_pkg::CH_COMMA) phase_n = PH_R;
								else if (sdcp_pkg::is_space(in_byte)) phase_n = PH_LSPACE;
								else if (in_byte == sdcp_pkg::CH_PLUS) phase_n = PH_LSIGN;
								else if (in_byte == sdcp_pkg::CH_MINUS) begin
									lneg_n  = 1'b1;
									phase_n = PH_LSIGN;
								end else if (sdcp_pkg::is_digit(in_byte)) begin
									lmag_n  = sdcp_pkg::add_digit(lmag_q, in_byte);
									phase_n = PH_LDIGIT;
								end else phase_n = PH_LDONE;
							end
							PH_LSIGN, PH_LDIGIT: begin
								priority if (in_byte == sdcp_pkg::CH_COMMA) phase_n = PH_R;
								else if (sdcp_pkg::is_digit(in_byte)) begin
									lmag_n  = sdcp_pkg::add_digit(lmag_q, in_byte);
									phase_n = PH_LDIGIT;
								end else phase_n = PH_LDONE;
							end
							PH_LDONE: begin
								if (in_byte == sdcp_pkg::CH_COMMA) phase_n = PH_R;
							end
							PH_R: begin
								phase_n = (in_byte == sdcp_pkg::CH_R) ? PH_RCOLON : PH_BAD;
							end
							PH_RCOLON: begin
								phase_n = (in_byte == sdcp_pkg::CH_COLON) ? PH_RSPACE : PH_BAD;
							end
							PH_RSPACE: begin
								priority if (sdcp_pkg::is_space(in_byte)) phase_n = PH_RSPACE;
								else if (in_byte == sdcp_pkg::CH_PLUS) phase_n = PH_RSIGN;
								else if (in_byte == sdcp_pkg::CH_MINUS) begin
									rneg_n  = 1'b1;
									phase_n = PH_RSIGN;
								end else if (sdcp_pkg::is_digit(in_byte)) begin
									rmag_n  = sdcp_pkg::add_digit(rmag_q, in_byte);
									phase_n = PH_RDIGIT;
								end else phase_n = PH_RDONE;
							end
							PH_RSIGN, PH_RDIGIT: begin
								if (sdcp_pkg::is_digit(in_byte)) begin
									rmag_n  = sdcp_pkg::add_digit(rmag_q, in_byte);
									phase_n = PH_RDIGIT;
								end else phase_n = PH_RDONE;
							end
							default: begin
								phase_n = phase_q;
							end
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			text_len_q <= '0;
			match_q    <= '1;
			pend_q     <= 1'b0;
			cut_q      <= 1'b0;
			phase_q    <= PH_L;
			lmag_q     <= '0;
			lneg_q     <= 1'b0;
			rmag_q     <= '0;
			rneg_q     <= 1'b0;
		end else begin
			line_len_q <= line_len_n;
			text_len_q <= text_len_n;
			match_q    <= match_n;
			pend_q     <= pend_n;
			cut_q      <= cut_n;
			phase_q    <= phase_n;
			lmag_q     <= lmag_n;
			lneg_q     <= lneg_n;
			rmag_q     <= rmag_n;
			rneg_q     <= rneg_n;
		end
	end

endmodule

// File: rtl/sdcp_queue.sv
// sdcp_queue: short FIFO of line summaries between front and back.
// Uses sdcp_pkg for the entry type.
`timescale 1ns / 1ps

module sdcp_queue #(
	parameter int DEPTH = sdcp_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  sdcp_pkg::line_summary_t push_data,
	output logic                    full,
	input  logic                    pop,
	output logic                    not_empty,
	output sdcp_pkg::line_summary_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sdcp_pkg::line_summary_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/sdcp_back.sv
// sdcp_back: turns a line summary into a command code and drive values,
// keeps the debug flag, and holds the result register. Uses sdcp_pkg.
`timescale 1ns / 1ps

module sdcp_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  sdcp_pkg::line_summary_t q_data,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [3:0]              out_code,
	output logic signed [8:0]       out_left,
	output logic signed [8:0]       out_right,
	output logic                    out_debug
);

	logic             valid_q;
	logic [3:0]       code_q;
	logic signed [8:0] left_q, right_q;
	logic             debug_q;
	logic [3:0]       code_c;
	logic [8:0]       left_c, right_c;

	assign q_pop = q_valid && (!valid_q || out_ready);

	// classify the line
	always_comb begin
		code_c  = sdcp_pkg::OPC_OTHER;
		left_c  = '0;
		right_c = '0;
		priority if (q_data.empty) begin
			code_c = sdcp_pkg::OPC_IDLE;
		end else if (q_data.is_drive) begin
			code_c = sdcp_pkg::OPC_IDLE;
			if (q_data.drive_ok) begin
				code_c  = sdcp_pkg::OPC_MOVE;
				left_c  = q_data.lneg ? 9'(9'd0 - {1'b0, q_data.lmag}) : {1'b0, q_data.lmag};
				right_c = q_data.rneg ? 9'(9'd0 - {1'b0, q_data.rmag}) : {1'b0, q_data.rmag};
			end
		end else begin
			// first keyword in table order wins
			for (int i = sdcp_pkg::KW_COUNT - 1; i >= 0; i--) begin
				if (q_data.hits[i]) code_c = sdcp_pkg::KW_CODE[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			debug_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				if (code_c == sdcp_pkg::OPC_DBG_SET) debug_q <= 1'b1;
				if (code_c == sdcp_pkg::OPC_DBG_CLR) debug_q <= 1'b0;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			code_q  <= code_c;
			left_q  <= left_c;
			right_q <= right_c;
		end
	end

	assign out_valid = valid_q;
	assign out_code  = code_q;
	assign out_left  = left_q;
	assign out_right = right_q;
	assign out_debug = debug_q;

endmodule

// File: rtl/serial_drive_command_parser.sv
// Serial drive command parser: one received byte per beat in, one command
// result per newline out. Throughput: one byte per cycle while the result queue is not full.
// Each result is written into the result queue when its newline beat is taken, then
// classified by the back into the output register, from which it is offered.
// s_tready drops only while the result queue is full, i.e. when m_tready stalls.
// Reset (arst_n low, asynchronous) empties the line, the queue and the debug flag.
`timescale 1ns / 1ps

module serial_drive_command_parser #(
	parameter int LINE_CAPACITY = sdcp_pkg::LINE_CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [8:0] left_drive, [17:9] right_drive, [18] debug_enabled
	output logic [3:0]  m_tuser   // [3:0] command_code
);

	sdcp_pkg::line_summary_t push_data, pop_data;
	logic        push, q_full, q_pop, q_valid;
	logic [3:0]  code;
	logic signed [8:0] left_drive, right_drive;
	logic        debug_enabled;

	sdcp_front #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	sdcp_queue #(
		.DEPTH(sdcp_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (pop_data)
	);

	sdcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (pop_data),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_code  (code),
		.out_left  (left_drive),
		.out_right (right_drive),
		.out_debug (debug_enabled)
	);

	assign m_tuser = code;
	assign m_tdata = {5'd0, debug_enabled, right_drive, left_drive};

endmodule

// File: rtl/sdcp_checker.sv
// sdcp_checker: port-level assertions for serial_drive_command_parser,
// bound to the top level. Uses assert_macros.svh and sdcp_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [3:0]  m_tuser
);

	// debug flag agrees with a debug command on the same beat
	logic dbg_ok;
	assign dbg_ok = (m_tuser != sdcp_pkg::OPC_DBG_SET || m_tdata[18]) &&
	                (m_tuser != sdcp_pkg::OPC_DBG_CLR || !m_tdata[18]);

	// a stalled result beat holds its payload
	`SDCP_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// only defined command codes
	`SDCP_ASSERT_OUT(a_code, m_tuser <= sdcp_pkg::OPC_OTHER)
	// drive values are zero except for a drive command, and never below -255
	`SDCP_ASSERT_OUT(a_drive, (m_tuser == sdcp_pkg::OPC_MOVE) || (m_tdata[17:0] == 18'd0))
	`SDCP_ASSERT_OUT(a_range, m_tdata[8:0] != 9'h100 && m_tdata[17:9] != 9'h100)
	// debug flag follows the debug commands
	`SDCP_ASSERT_OUT(a_debug, dbg_ok)

endmodule

bind serial_drive_command_parser sdcp_checker u_sdcp_checker (.*);
